// ===== rtl/fwlt_pkg.sv =====
// ----------------------------------------------------------------------------
// fwlt_pkg
// shared constants, codes and types for the tagged record fifo
// ----------------------------------------------------------------------------
`default_nettype none

package fwlt_pkg;

  localparam int SLOTS     = 16;
  localparam int TAG_W     = 4;
  localparam int OCC_W     = 5;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int WORD_W    = 64;
  localparam int STAMP_W   = 32;
  localparam int FULL_ADDR_W = 2 * WORD_W;

  localparam int DEF_MAX_ENTRIES   = 16;
  localparam int DEF_ADDRESS_BYTES = 16;

  // request codes
  localparam logic [FUNC_W-1:0] FN_PUSH   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_POP    = 2'd1;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_TAG    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef logic [SLOTS-1:0] tag_mask_t;

  typedef struct packed {
    logic             found;
    logic [TAG_W-1:0] tag;
  } tag_alloc_t;

  // zero every byte from the first zero byte on, and every byte past nbytes
  function automatic logic [FULL_ADDR_W-1:0] trim_addr(
    input logic [FULL_ADDR_W-1:0] a,
    input int unsigned            nbytes
  );
    logic                   ended;
    logic [FULL_ADDR_W-1:0] r;
    ended = 1'b0;
    r     = '0;
    for (int unsigned i = 0; i < FULL_ADDR_W / 8; i++) begin
      if (i >= nbytes || a[8*i +: 8] == 8'd0) begin
        ended = 1'b1;
      end
      r[8*i +: 8] = ended ? 8'd0 : a[8*i +: 8];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fifo_with_lowest_free_tag.sv =====
// ----------------------------------------------------------------------------
// fifo_with_lowest_free_tag
// bounded fifo of address/timestamp records, each given the lowest free tag
// ----------------------------------------------------------------------------
// Handles one request at a time. A push, a clear, or any request that fails
// goes from S_IDLE to S_OUT; a lookup does too (one record-ram read); a pop
// passes through S_RING between them, since it first reads the oldest tag
// from the order ring and then reads the record ram at that tag. Both rams
// have a registered read, and those reads set the state sequence. A result
// waiting in the output register keeps S_OUT only while out_stall is held.
// Records are indexed by tag; the order ring holds tags in arrival order.
`default_nettype none

module fifo_with_lowest_free_tag #(
  parameter int MAX_ENTRIES   = fwlt_pkg::DEF_MAX_ENTRIES,
  parameter int ADDRESS_BYTES = fwlt_pkg::DEF_ADDRESS_BYTES
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [fwlt_pkg::FUNC_W-1:0]     in_func,
  input  wire logic [fwlt_pkg::WORD_W-1:0]     in_address_low,
  input  wire logic [fwlt_pkg::WORD_W-1:0]     in_address_high,
  input  wire logic [fwlt_pkg::STAMP_W-1:0]    in_stamp,
  input  wire logic [fwlt_pkg::TAG_W-1:0]      in_query_tag,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [fwlt_pkg::STATUS_W-1:0]   out_status,
  output logic      [fwlt_pkg::TAG_W-1:0]      out_tag,
  output logic      [fwlt_pkg::WORD_W-1:0]     out_address_low,
  output logic      [fwlt_pkg::WORD_W-1:0]     out_address_high,
  output logic      [fwlt_pkg::STAMP_W-1:0]    out_stamp,
  output logic      [fwlt_pkg::OCC_W-1:0]      out_occupancy
);

  import fwlt_pkg::*;

  localparam int CAPACITY = (MAX_ENTRIES < SLOTS) ? MAX_ENTRIES : SLOTS;
  localparam int REC_AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int ADDR_W   = 8 * ADDRESS_BYTES;
  localparam int REC_W    = ADDR_W + STAMP_W;
  localparam int RING_AW  = $clog2(SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RING = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [TAG_W-1:0]    head_r, head_nxt;
  logic [OCC_W-1:0]    count_r, count_nxt;
  tag_mask_t           tags_r, tags_nxt;
  logic [TAG_W-1:0]    tag_r, tag_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                rec_r, rec_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [TAG_W-1:0]    out_tag_r;
  logic [WORD_W-1:0]   out_lo_r, out_hi_r;
  logic [STAMP_W-1:0]  out_stamp_r;
  logic [OCC_W-1:0]    out_occ_r;

  logic                accept;
  logic                out_free;
  logic                lookup_hit;
  tag_alloc_t          alloc;

  logic                rec_we;
  logic [REC_AW-1:0]   rec_waddr, rec_raddr;
  logic [REC_W-1:0]    rec_wdata, rec_rdata;
  logic                ring_we;
  logic [RING_AW-1:0]  ring_waddr;
  logic [TAG_W-1:0]    ring_rdata;

  logic [FULL_ADDR_W-1:0] trimmed;
  logic [FULL_ADDR_W-1:0] rec_addr_full;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign lookup_hit = ({1'b0, in_query_tag} < OCC_W'(CAPACITY)) && tags_r[in_query_tag];

  assign trimmed    = trim_addr({in_address_high, in_address_low}, ADDRESS_BYTES);
  assign rec_wdata  = {in_stamp, trimmed[ADDR_W-1:0]};
  assign rec_waddr  = alloc.tag[REC_AW-1:0];
  assign ring_waddr = RING_AW'(head_r + count_r[TAG_W-1:0]);

  fwlt_tag_alloc #(
    .CAPACITY (CAPACITY)
  ) u_tag_alloc (
    .tags_in_use (tags_r),
    .alloc       (alloc)
  );

  fwlt_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY),
    .AW    (REC_AW)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  // ring read address sits on the head, so the oldest tag is ready in the next cycle
  fwlt_ram #(
    .WIDTH (TAG_W),
    .DEPTH (SLOTS),
    .AW    (RING_AW)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (alloc.tag),
    .raddr (head_r),
    .rdata (ring_rdata)
  );

  // record read address is held on tag_r while the result waits
  always_comb begin
    case (state_r)
      S_IDLE:  rec_raddr = in_query_tag[REC_AW-1:0];
      S_RING:  rec_raddr = ring_rdata[REC_AW-1:0];
      default: rec_raddr = tag_r[REC_AW-1:0];
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    tags_nxt   = tags_r;
    tag_nxt    = tag_r;
    status_nxt = status_r;
    rec_nxt    = rec_r;
    rec_we     = 1'b0;
    ring_we    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt  = S_OUT;
          status_nxt = ST_OK;
          tag_nxt    = '0;
          rec_nxt    = 1'b0;
          case (in_func)
            FN_PUSH: begin
              if (alloc.found) begin
                rec_we    = 1'b1;
                ring_we   = 1'b1;
                tags_nxt  = tags_r | (tag_mask_t'(1) << alloc.tag);
                count_nxt = count_r + OCC_W'(1);
                tag_nxt   = alloc.tag;
              end else begin
                status_nxt = ST_NO_TAG;
              end
            end
            FN_POP: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_RING;
              end
            end
            FN_LOOKUP: begin
              if (lookup_hit) begin
                tag_nxt = in_query_tag;
                rec_nxt = 1'b1;
              end else begin
                status_nxt = ST_NOT_FOUND;
              end
            end
            FN_CLEAR: begin
              head_nxt  = '0;
              count_nxt = '0;
              tags_nxt  = '0;
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_RING: begin
        tag_nxt   = ring_rdata;
        rec_nxt   = 1'b1;
        tags_nxt  = tags_r & ~(tag_mask_t'(1) << ring_rdata);
        head_nxt  = head_r + TAG_W'(1);
        count_nxt = count_r - OCC_W'(1);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rec_addr_full = FULL_ADDR_W'(rec_rdata[ADDR_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      tags_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      tags_r  <= tags_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_r    <= tag_nxt;
    status_r <= status_nxt;
    rec_r    <= rec_nxt;
    if (state_r == S_OUT && out_free) begin
      out_status_r <= status_r;
      out_tag_r    <= tag_r;
      out_occ_r    <= count_r;
      out_lo_r     <= rec_r ? rec_addr_full[WORD_W-1:0] : '0;
      out_hi_r     <= rec_r ? rec_addr_full[FULL_ADDR_W-1:WORD_W] : '0;
      out_stamp_r  <= rec_r ? rec_rdata[REC_W-1:ADDR_W] : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_tag          = out_tag_r;
  assign out_address_low  = out_lo_r;
  assign out_address_high = out_hi_r;
  assign out_stamp        = out_stamp_r;
  assign out_occupancy    = out_occ_r;

endmodule

`default_nettype wire

// ===== rtl/fwlt_ram.sv =====
// ----------------------------------------------------------------------------
// fwlt_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module fwlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/fwlt_tag_alloc.sv =====
// ----------------------------------------------------------------------------
// fwlt_tag_alloc
// finds the lowest tag below the capacity that is not in use
// ----------------------------------------------------------------------------
`default_nettype none

module fwlt_tag_alloc #(
  parameter int CAPACITY = 16
) (
  input  wire fwlt_pkg::tag_mask_t  tags_in_use,
  output fwlt_pkg::tag_alloc_t      alloc
);

  import fwlt_pkg::*;

  // scan downwards so the lowest free tag wins
  always_comb begin
    alloc = '0;
    for (int t = SLOTS - 1; t >= 0; t--) begin
      if (t < CAPACITY && !tags_in_use[t]) begin
        alloc.found = 1'b1;
        alloc.tag   = TAG_W'(t);
      end
    end
  end

endmodule

`default_nettype wire

// ===== test/fifo_with_lowest_free_tag_tb.sv =====
// ----------------------------------------------------------------------------
// fifo_with_lowest_free_tag_tb
// self-checking bench for the tagged record fifo
// ----------------------------------------------------------------------------
// Each accepted request goes through a local model of the queue, and the
// reply it predicts is queued. A checker takes every reply the block returns
// and compares it field by field with the oldest prediction. A short
// directed part covers the empty and full queue, tag reuse, lookup misses
// and the string trimming of addresses. Random phases with different request
// mixes follow. Both handshakes idle and stall at random.
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_lowest_free_tag_tb;

  import fwlt_pkg::*;

  localparam int TB_CAPACITY   = (DEF_MAX_ENTRIES < 16) ? DEF_MAX_ENTRIES : 16;
  localparam int TB_ADDR_BYTES = DEF_ADDRESS_BYTES;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    tag;
    logic [WORD_W-1:0]   addr_lo;
    logic [WORD_W-1:0]   addr_hi;
    logic [STAMP_W-1:0]  stamp;
    logic [OCC_W-1:0]    occupancy;
  } fifo_reply_t;

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   in_func         = FN_PUSH;
  logic [WORD_W-1:0]   in_address_low  = '0;
  logic [WORD_W-1:0]   in_address_high = '0;
  logic [STAMP_W-1:0]  in_stamp        = '0;
  logic [TAG_W-1:0]    in_query_tag    = '0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [TAG_W-1:0]    out_tag;
  logic [WORD_W-1:0]   out_address_low;
  logic [WORD_W-1:0]   out_address_high;
  logic [STAMP_W-1:0]  out_stamp;
  logic [OCC_W-1:0]    out_occupancy;

  // local copy of the queue state
  logic [WORD_W-1:0]  rec_addr_lo [SLOTS];
  logic [WORD_W-1:0]  rec_addr_hi [SLOTS];
  logic [STAMP_W-1:0] rec_stamp   [SLOTS];
  logic [TAG_W-1:0]   arrival_ring[SLOTS];
  logic [TAG_W-1:0]   oldest_slot = '0;
  logic [OCC_W-1:0]   held_count  = '0;
  logic [SLOTS-1:0]   busy_tags   = '0;

  fifo_reply_t expected_replies[$];

  bit quiet_mode = 1'b0;
  int error_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  int requests_sent = 0;
  int replies_seen = 0;
  int pushes_taken = 0;
  int refused_full = 0;
  int refused_empty = 0;
  int lookup_hits = 0;
  int lookup_misses = 0;
  int clears_sent = 0;

  fifo_with_lowest_free_tag #(
    .MAX_ENTRIES  (DEF_MAX_ENTRIES),
    .ADDRESS_BYTES(DEF_ADDRESS_BYTES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_address_low  (in_address_low),
    .in_address_high (in_address_high),
    .in_stamp        (in_stamp),
    .in_query_tag    (in_query_tag),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_tag         (out_tag),
    .out_address_low (out_address_low),
    .out_address_high(out_address_high),
    .out_stamp       (out_stamp),
    .out_occupancy   (out_occupancy)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fifo_with_lowest_free_tag_tb failed");
      $finish;
    end
  end

  function automatic int idle_cycles();
    if (quiet_mode) begin
      return 0;
    end
    if ($urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // apply one accepted request to the local queue and return its reply
  function automatic fifo_reply_t compute_reply(
    input logic [FUNC_W-1:0]  func,
    input logic [WORD_W-1:0]  lo,
    input logic [WORD_W-1:0]  hi,
    input logic [STAMP_W-1:0] stamp,
    input logic [TAG_W-1:0]   qtag
  );
    fifo_reply_t        r;
    logic [2*WORD_W-1:0] full;
    int                 len;
    logic               found;
    logic [TAG_W-1:0]   t;
    r = '{status: ST_OK, tag: '0, addr_lo: '0, addr_hi: '0, stamp: '0, occupancy: '0};
    case (func)
      FN_PUSH: begin
        found = 1'b0;
        t = '0;
        for (int i = 0; i < TB_CAPACITY; i++) begin
          if (!found && !busy_tags[i]) begin
            t = TAG_W'(i);
            found = 1'b1;
          end
        end
        if (!found) begin
          r.status = ST_NO_TAG;
          refused_full++;
        end else begin
          // address is a string: cut at the first zero byte or the byte limit
          full = {hi, lo};
          len = 0;
          while (len < TB_ADDR_BYTES && len < 16 && full[8*len +: 8] != 8'd0) begin
            len++;
          end
          for (int i = len; i < 16; i++) begin
            full[8*i +: 8] = 8'd0;
          end
          rec_addr_lo[t] = full[WORD_W-1:0];
          rec_addr_hi[t] = full[2*WORD_W-1:WORD_W];
          rec_stamp[t] = stamp;
          arrival_ring[TAG_W'(oldest_slot + held_count)] = t;
          busy_tags[t] = 1'b1;
          held_count = held_count + 1'b1;
          r.tag = t;
          pushes_taken++;
        end
      end
      FN_POP: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
          refused_empty++;
        end else begin
          t = arrival_ring[oldest_slot];
          r.tag = t;
          r.addr_lo = rec_addr_lo[t];
          r.addr_hi = rec_addr_hi[t];
          r.stamp = rec_stamp[t];
          busy_tags[t] = 1'b0;
          oldest_slot = oldest_slot + 1'b1;
          held_count = held_count - 1'b1;
        end
      end
      FN_LOOKUP: begin
        if (int'(qtag) < TB_CAPACITY && busy_tags[qtag]) begin
          r.tag = qtag;
          r.addr_lo = rec_addr_lo[qtag];
          r.addr_hi = rec_addr_hi[qtag];
          r.stamp = rec_stamp[qtag];
          lookup_hits++;
        end else begin
          r.status = ST_NOT_FOUND;
          lookup_misses++;
        end
      end
      default: begin
        oldest_slot = '0;
        held_count = '0;
        busy_tags = '0;
        clears_sent++;
      end
    endcase
    r.occupancy = held_count;
    return r;
  endfunction

  function automatic logic [2*WORD_W-1:0] rand_address();
    logic [2*WORD_W-1:0] a;
    int                  cut;
    case ($urandom_range(0, 4))
      0: a = {$urandom, $urandom, $urandom, $urandom};
      1, 2: begin
        for (int i = 0; i < 16; i++) begin
          a[8*i +: 8] = 8'($urandom_range(1, 255));
        end
        cut = $urandom_range(0, 16);
        if (cut < 16) begin
          a[8*cut +: 8] = 8'd0;
        end
      end
      3: a = '1;
      default: begin
        for (int i = 0; i < 16; i++) begin
          a[8*i +: 8] = 8'($urandom_range(1, 255));
        end
      end
    endcase
    return a;
  endfunction

  function automatic logic [STAMP_W-1:0] rand_stamp();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // called at a rising edge, returns at the edge where the request is taken
  task automatic send_request(
    input logic [FUNC_W-1:0]   func,
    input logic [2*WORD_W-1:0] addr,
    input logic [STAMP_W-1:0]  stamp,
    input logic [TAG_W-1:0]    qtag
  );
    int gap;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_address_low <= addr[WORD_W-1:0];
    in_address_high <= addr[2*WORD_W-1:WORD_W];
    in_stamp <= stamp;
    in_query_tag <= qtag;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_replies.push_back(compute_reply(func, addr[WORD_W-1:0],
                                             addr[2*WORD_W-1:WORD_W], stamp, qtag));
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // reply checker and receiver stall
  always @(posedge clk) begin
    fifo_reply_t e;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        replies_seen++;
        if (expected_replies.size() == 0) begin
          $error("reply with no request outstanding: status %0d tag %0d",
                 out_status, out_tag);
          error_count++;
        end else begin
          e = expected_replies.pop_front();
          check_field("status", 64'(e.status), 64'(out_status));
          check_field("tag", 64'(e.tag), 64'(out_tag));
          check_field("address_low", e.addr_lo, out_address_low);
          check_field("address_high", e.addr_hi, out_address_high);
          check_field("stamp", 64'(e.stamp), 64'(out_stamp));
          check_field("occupancy", 64'(e.occupancy), 64'(out_occupancy));
        end
        stall_left = idle_cycles();
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  task automatic test_empty_queue();
    send_request(FN_POP, rand_address(), rand_stamp(), 4'd0);
    send_request(FN_LOOKUP, rand_address(), rand_stamp(), 4'd15);
    send_request(FN_CLEAR, '1, '1, 4'd15);
  endtask

  task automatic test_fill_and_overflow();
    logic [2*WORD_W-1:0] a;
    logic [STAMP_W-1:0]  s;
    for (int i = 0; i < TB_CAPACITY; i++) begin
      s = rand_stamp();
      case (i)
        0: begin a = '1; s = '1; end
        1: begin a = '0; s = '0; end
        2: a = {64'h0102030405060708, 64'h1112131415160018};  // zero in the low word
        3: a = {64'h00AABBCCDDEEFF11, 64'h2122232425262728};  // zero as the last byte
        4: a = {64'h8182838485868788, 64'h9192939495969700};  // zero first byte
        default: a = rand_address();
      endcase
      send_request(FN_PUSH, a, s, TAG_W'($urandom_range(0, 15)));
    end
    // one more push with every tag taken
    send_request(FN_PUSH, rand_address(), rand_stamp(), 4'd0);
    send_request(FN_LOOKUP, rand_address(), rand_stamp(), 4'd0);
  endtask

  task automatic test_tag_reuse();
    send_request(FN_POP, rand_address(), rand_stamp(), 4'd0);
    // the popped record was tag 0, so it is gone and its tag is free again
    send_request(FN_LOOKUP, rand_address(), rand_stamp(), 4'd0);
    send_request(FN_PUSH, rand_address(), rand_stamp(), 4'd0);
    send_request(FN_CLEAR, rand_address(), rand_stamp(), 4'd0);
  endtask

  task automatic run_phase(input int count, input int push_w, input int pop_w,
                           input int look_w);
    int                 pick;
    int                 start;
    logic [FUNC_W-1:0]  func;
    logic [TAG_W-1:0]   qtag;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      qtag = TAG_W'($urandom_range(0, 15));
      if (pick < 2) begin
        func = FN_CLEAR;
      end else begin
        pick = $urandom_range(0, push_w + pop_w + look_w - 1);
        if (pick < push_w) begin
          func = FN_PUSH;
        end else if (pick < push_w + pop_w) begin
          func = FN_POP;
        end else begin
          func = FN_LOOKUP;
          // mostly ask for a tag that is held
          if (busy_tags != 0 && $urandom_range(0, 9) < 8) begin
            start = $urandom_range(0, 15);
            for (int k = 15; k >= 0; k--) begin
              if (busy_tags[(start + k) % 16]) begin
                qtag = TAG_W'((start + k) % 16);
              end
            end
          end
        end
      end
      send_request(func, rand_address(), rand_stamp(), qtag);
    end
  endtask

  task automatic test_random_traffic();
    run_phase(300, 40, 30, 28);
    run_phase(250, 65, 15, 18);
    wait_drained();
    run_phase(250, 15, 60, 23);
    quiet_mode = 1'b1;
    run_phase(300, 40, 30, 28);
    wait_drained();
    quiet_mode = 1'b0;
    run_phase(200, 65, 15, 18);
    run_phase(200, 35, 25, 38);
    wait_drained();
    run_phase(250, 15, 60, 23);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_fill_and_overflow();
    test_tag_reuse();
    wait_drained();
    test_random_traffic();
    wait_drained();
    $display("covered %0d requests, %0d replies: %0d pushes stored, %0d clears",
             requests_sent, replies_seen, pushes_taken, clears_sent);
    $display("refusals: %0d full, %0d empty; lookups: %0d hits, %0d misses",
             refused_full, refused_empty, lookup_hits, lookup_misses);
    if (error_count == 0) begin
      $display("fifo_with_lowest_free_tag_tb passed");
    end else begin
      $display("fifo_with_lowest_free_tag_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/fwlt_pkg.sv
rtl/fwlt_ram.sv
rtl/fwlt_tag_alloc.sv
rtl/fifo_with_lowest_free_tag.sv
test/fifo_with_lowest_free_tag_tb.sv
